// ===== sv/fcf_pkg.sv =====
// package: shared types and constants of the fir convolution filter
`timescale 1ns / 1ps
`default_nettype none
package fcf_pkg;

	localparam int DEF_MAX_TAPS    = 64;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int COEF_IDX_BITS   = 6;
	localparam int TAP_CNT_BITS    = 7;
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;

	localparam logic [TAP_CNT_BITS-1:0] TAP_CNT_RESET = 7'd64;

	// register index, taken from paddr[2]
	localparam logic REG_TAP_COUNT = 1'b0;

	// opcode carried in s_tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} fcf_state_t;

endpackage
`default_nettype wire

// ===== sv/fcf_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fcf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/fir_convolution_filter.sv =====
// top level: direct-form fir filter with coefficient and history rams
// flow: an accepted sample issues T tap reads, T = effective tap count; the ram read,
//   product and accumulator registers drain, then the output register takes the result
// pacing: one sample at a time, through the single multiply-accumulate loop that
//   reads one coefficient and one history entry per cycle, stalled while a held
//   result blocks the output register; one coefficient write per cycle while idle
// reset: a clearing pass zeroes both rams, s_tready low meanwhile
`timescale 1ns / 1ps
`default_nettype none
module fir_convolution_filter #(
	parameter int MAX_TAPS    = fcf_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_BITS = fcf_pkg::DEF_SAMPLE_BITS,
	localparam int S_TDATA_W  = ((2 * SAMPLE_BITS + fcf_pkg::COEF_IDX_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// apb configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [fcf_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [fcf_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic      [fcf_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                     pready,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [S_TDATA_W-1:0]                s_tdata,  // sample_in, coef_index, coef_value
	input  wire logic                                s_tuser,  // opcode
	input  wire logic                                s_tlast,  // end_of_block
	// output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [M_TDATA_W-1:0]                m_tdata,  // filtered_sample
	output logic                                     m_tlast   // block_last
);

	import fcf_pkg::*;

	localparam int AW     = $clog2(MAX_TAPS);
	localparam int TW     = $clog2(MAX_TAPS + 1);
	localparam int PW     = 2 * SAMPLE_BITS;
	localparam int ACC_FULL = PW + $clog2(MAX_TAPS) + 1;
	localparam int ACC_W  = (ACC_FULL > 64) ? 64 : ACC_FULL;

	localparam logic signed [ACC_W-1:0] Y_MAX =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 1;
	localparam logic signed [ACC_W-1:0] RND =
		ACC_W'(64'sd1 <<< (SAMPLE_BITS - 2));

	// input fields
	logic signed [SAMPLE_BITS-1:0]   sample_in;
	logic        [COEF_IDX_BITS-1:0] coef_index;
	logic signed [SAMPLE_BITS-1:0]   coef_value;

	assign sample_in  = s_tdata[SAMPLE_BITS-1:0];
	assign coef_index = s_tdata[SAMPLE_BITS +: COEF_IDX_BITS];
	assign coef_value = s_tdata[SAMPLE_BITS + COEF_IDX_BITS +: SAMPLE_BITS];

	// configuration
	logic [TAP_CNT_BITS-1:0] tap_count_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_TAP_COUNT);
	assign prdata = (paddr[2] == REG_TAP_COUNT) ?
		{{(APB_DATA_BITS - TAP_CNT_BITS){1'b0}}, tap_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_RESET;
		end else if (cfg_wr) begin
			tap_count_q <= pwdata[TAP_CNT_BITS-1:0];
		end
	end

	// control
	fcf_state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] ptr_q;
	logic [TW-1:0] left_q;
	logic          valid_s1, valid_s2;
	logic          m_tvalid_q;

	logic clr_en, issue, out_load;
	logic xfer, sample_acc, coef_acc, coef_ok;
	logic [TW-1:0] taps_eff;

	assign xfer       = s_tvalid & s_tready;
	assign sample_acc = xfer & (s_tuser == OP_SAMPLE);
	assign coef_acc   = xfer & (s_tuser == OP_COEF);
	assign coef_ok    = 32'(coef_index) < 32'(MAX_TAPS);

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TW'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps_eff = TW'(MAX_TAPS);
		end else begin
			taps_eff = TW'(tap_count_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(MAX_TAPS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sample_acc) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (left_q == TW'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		clr_en   = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: clr_en = 1'b1;
			ST_IDLE:  s_tready = 1'b1;
			ST_MAC:   issue = 1'b1;
			ST_DRAIN: ;
			ST_ROUND: out_load = !m_tvalid_q || m_tready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			j_q        <= '0;
			ptr_q      <= '0;
			left_q     <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (sample_acc) begin
				ptr_q  <= head_q;
				j_q    <= '0;
				left_q <= taps_eff;
				head_q <= (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + 1'b1;
			end else if (issue) begin
				ptr_q  <= (ptr_q == '0) ? AW'(MAX_TAPS - 1) : ptr_q - 1'b1;
				j_q    <= j_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// memories
	logic                      coef_we, hist_we;
	logic [AW-1:0]             coef_waddr, hist_waddr;
	logic [SAMPLE_BITS-1:0]    coef_wdata, hist_wdata;
	logic signed [SAMPLE_BITS-1:0] coef_rd, hist_rd;

	assign coef_we    = clr_en | (coef_acc & coef_ok);
	assign coef_waddr = clr_en ? clr_q : AW'(coef_index);
	assign coef_wdata = clr_en ? '0 : coef_value;
	assign hist_we    = clr_en | sample_acc;
	assign hist_waddr = clr_en ? clr_q : head_q;
	assign hist_wdata = clr_en ? '0 : sample_in;

	fcf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_TAPS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_wdata),
		.re   (issue),
		.raddr(j_q),
		.rdata(coef_rd)
	);

	fcf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_TAPS)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re   (issue),
		.raddr(ptr_q),
		.rdata(hist_rd)
	);

	// multiply-accumulate datapath
	logic signed [PW-1:0]    prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    eob_q;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= coef_rd * hist_rd;
		end
		if (sample_acc) begin
			acc_q <= '0;
			eob_q <= s_tlast;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round to nearest and saturate
	logic signed [ACC_W-1:0]       rnd_sum, shifted;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	always_comb begin
		rnd_sum = acc_q + RND;
		shifted = rnd_sum >>> (SAMPLE_BITS - 1);
		if (shifted > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_BITS-1:0];
		end else if (shifted < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	logic [SAMPLE_BITS-1:0] m_data_q;
	logic                   m_last_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= y_sat;
			m_last_q <= eob_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_data_q);
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire

// ===== dv/fcf_checker.sv =====
// checker for the fir filter: predicts sample outputs, compares the result stream and tap_count readback
`timescale 1ns / 1ps
module fcf_checker #(
	parameter int S_TDATA_W = 40,
	parameter int M_TDATA_W = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcf_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [fcf_pkg::APB_DATA_BITS-1:0]   pwdata,
	input  logic [fcf_pkg::APB_DATA_BITS-1:0]   prdata,
	input  logic                                pready,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [S_TDATA_W-1:0]                s_tdata,  // sample_in, coef_index, coef_value
	input  logic                                s_tuser,  // opcode
	input  logic                                s_tlast,  // end_of_block
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [M_TDATA_W-1:0]                m_tdata,  // filtered_sample
	input  logic                                m_tlast,  // block_last
	output int                                  fail_count,
	output int                                  outstanding,
	output int                                  samples_seen,
	output int                                  coefs_seen,
	output int                                  results_seen
);
	import fcf_pkg::*;

	localparam int NTAPS = DEF_MAX_TAPS;
	localparam int SB    = DEF_SAMPLE_BITS;
	localparam int IB    = COEF_IDX_BITS;

	typedef struct packed {
		logic signed [SB-1:0] value;
		logic                 last;
	} fir_out_t;

	logic signed [SB-1:0]           coef_taps [NTAPS];
	logic signed [SB-1:0]           delay_line [NTAPS];
	logic [IB-1:0]                  head;
	logic [TAP_CNT_BITS-1:0]        tap_reg;
	fir_out_t                       expected_outputs [$];

	function automatic logic signed [SB-1:0] filter_response();
		longint acc;
		longint y;
		int n;
		int j;
		logic [IB-1:0] pos;
		n = (tap_reg == 0) ? 1 : ((tap_reg > NTAPS) ? NTAPS : int'(tap_reg));
		acc = 0;
		for (j = 0; j < n; j++) begin
			pos = head - IB'(j);
			acc += longint'(coef_taps[j]) * longint'(delay_line[pos]);
		end
		acc += longint'(1) << (SB - 2);
		y = acc >>> (SB - 1);
		if (y > longint'(2 ** (SB - 1) - 1))
			y = 2 ** (SB - 1) - 1;
		if (y < -longint'(2 ** (SB - 1)))
			y = -longint'(2 ** (SB - 1));
		return y[SB-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fir_out_t exp_item;
		int i;
		if (!arst_n) begin
			for (i = 0; i < NTAPS; i++) begin
				coef_taps[i]  = '0;
				delay_line[i] = '0;
			end
			head         = '0;
			tap_reg      = TAP_CNT_RESET;
			fail_count   = 0;
			outstanding  = 0;
			samples_seen = 0;
			coefs_seen   = 0;
			results_seen = 0;
			expected_outputs.delete();
		end else begin
			if (psel && penable && pready && paddr[APB_ADDR_BITS-1:2] == REG_TAP_COUNT) begin
				if (pwrite) begin
					tap_reg = pwdata[TAP_CNT_BITS-1:0];
				end else if (prdata !== APB_DATA_BITS'(tap_reg)) begin
					$display("%0t: tap_count readback mismatch, expected %0d actual %0d",
						$time, tap_reg, prdata);
					fail_count++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_COEF) begin
					coef_taps[s_tdata[SB+IB-1:SB]] = s_tdata[2*SB+IB-1:SB+IB];
					coefs_seen++;
				end else begin
					delay_line[head] = s_tdata[SB-1:0];
					exp_item.value   = filter_response();
					exp_item.last    = s_tlast;
					expected_outputs.push_back(exp_item);
					head = head + 1'b1;
					samples_seen++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected output transaction, expected none actual %0d last %0b",
						$time, $signed(m_tdata[SB-1:0]), m_tlast);
					fail_count++;
				end else begin
					exp_item = expected_outputs.pop_front();
					if (m_tdata[SB-1:0] !== exp_item.value) begin
						$display("%0t: filtered_sample mismatch, expected %0d actual %0d",
							$time, exp_item.value, $signed(m_tdata[SB-1:0]));
						fail_count++;
					end
					if (m_tlast !== exp_item.last) begin
						$display("%0t: block_last mismatch, expected %0b actual %0b",
							$time, exp_item.last, m_tlast);
						fail_count++;
					end
					results_seen++;
				end
			end
			outstanding = expected_outputs.size();
		end
	end

endmodule

// ===== dv/fir_convolution_filter_tb.sv =====
// testbench top: stimulus, sink backpressure and verdict for the fir filter
`timescale 1ns / 1ps
module fir_convolution_filter_tb;
	import fcf_pkg::*;

	localparam int SB        = DEF_SAMPLE_BITS;
	localparam int IB        = COEF_IDX_BITS;
	localparam int S_TDATA_W = ((2 * SB + IB + 7) / 8) * 8;
	localparam int M_TDATA_W = ((SB + 7) / 8) * 8;
	localparam int LIMIT     = 1000000;
	localparam int DRAIN     = DEF_MAX_TAPS + 16;
	localparam int PHASES    = 12;
	localparam int PHASE_LEN = 120;
	localparam logic [APB_ADDR_BITS-1:0] TAP_ADDR = {REG_TAP_COUNT, 2'b00};

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [S_TDATA_W-1:0]      s_tdata;
	logic                      s_tuser;
	logic                      s_tlast;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [M_TDATA_W-1:0]      m_tdata;
	logic                      m_tlast;

	int fail_count;
	int outstanding;
	int samples_seen;
	int coefs_seen;
	int results_seen;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_left;
	int cycles;

	logic [TAP_CNT_BITS-1:0] tap_plan [PHASES] = '{
		7'd1, 7'd0, 7'd127, 7'd64, 7'd65, 7'd2, 7'd5, 7'd16, 7'd33, 7'd100, 7'd3, 7'd63
	};

	fir_convolution_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	fcf_checker #(
		.S_TDATA_W (S_TDATA_W),
		.M_TDATA_W (M_TDATA_W)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.samples_seen (samples_seen),
		.coefs_seen   (coefs_seen),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d results still awaited", $time, cycles,
			outstanding);
		$display("[FAIL] regression broken");
		$finish;
	end

	// sink: random stalls, plus a long hold counted here
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	function automatic logic [SB-1:0] rand_q15();
		case ($urandom_range(9))
			0:       return {1'b0, {(SB-1){1'b1}}};
			1:       return {1'b1, {(SB-1){1'b0}}};
			2:       return SB'($signed($urandom_range(64)) - 32);
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic apb_access(input logic wr, input logic [TAP_CNT_BITS-1:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = TAP_ADDR;
		pwdata  = APB_DATA_BITS'(val);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic send_item(input logic op, input logic [SB-1:0] smp, input logic [IB-1:0] idx,
		input logic [SB-1:0] cval, input logic eob);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata  = S_TDATA_W'({$urandom, $urandom});
			s_tuser  = 1'($urandom);
			s_tlast  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = S_TDATA_W'({cval, idx, smp});
		s_tlast  = eob;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic push_sample(input logic [SB-1:0] smp, input logic eob);
		send_item(OP_SAMPLE, smp, IB'($urandom), SB'($urandom), eob);
	endtask

	task automatic load_coef(input logic [IB-1:0] idx, input logic [SB-1:0] cval);
		send_item(OP_COEF, SB'($urandom), idx, cval, 1'($urandom));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		int p;
		int k;
		int eff;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_SAMPLE;
		s_tlast        = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_left      = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		apb_access(1'b0, '0);

		// zero coefficients, then rounding ties both ways
		push_sample(16'h7FFF, 1'b1);
		load_coef(6'd0, 16'h0001);
		load_coef(6'd63, 16'h8000);
		push_sample(16'h4000, 1'b0);
		push_sample(16'hC000, 1'b1);
		// positive saturation
		load_coef(6'd0, 16'h7FFF);
		load_coef(6'd1, 16'h7FFF);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h7FFF, 1'b0);
		// negative saturation, then most negative squared
		load_coef(6'd0, 16'h8000);
		load_coef(6'd1, 16'h8000);
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h8000, 1'b1);
		load_coef(6'd63, 16'hFFFF);
		push_sample(16'h0000, 1'b0);
		wait_idle();

		for (p = 0; p < PHASES; p++) begin
			apb_access(1'b1, tap_plan[p]);
			apb_access(1'b0, '0);
			eff = (tap_plan[p] == 0) ? 1 :
				((tap_plan[p] > DEF_MAX_TAPS) ? DEF_MAX_TAPS : int'(tap_plan[p]));
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
				default: begin src_idle_pct = 9; sink_stall_pct = 9; end
			endcase
			if (p == 5) begin
				@(posedge clk);
				hold_left = 300;
			end
			for (k = 0; k < PHASE_LEN; k++) begin
				if ($urandom_range(99) < 15)
					load_coef($urandom_range(1) ? IB'($urandom_range(DEF_MAX_TAPS - 1)) :
						IB'($urandom_range(eff - 1)), rand_q15());
				else
					push_sample(rand_q15(), ($urandom_range(7) == 0));
			end
			wait_idle();
		end

		$display("run covered %0d samples and %0d coefficient writes over %0d tap settings",
			samples_seen, coefs_seen, PHASES + 1);
		$display("%0d results checked under source gaps, sink stalls and one long sink hold",
			results_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
